// ----- src/weno5_reconstruct_core_macros.svh -----
// Assertion macros shared by the WENO5 reconstruction RTL.
`ifndef WENO5_RECONSTRUCT_CORE_MACROS_SVH
`define WENO5_RECONSTRUCT_CORE_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define W5R_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define W5R_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/w5r_pkg.sv -----
// Package: widths, constants, types and helpers of the WENO5 reconstruction core.
package w5r_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int WEIGHT_BITS = 16;
    localparam int MANT_BITS   = 10;
    localparam int EPS_W       = 32;
    localparam int MAG_W       = 27;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int S_W         = 57;
    localparam int CHUNKS      = 8;
    localparam int LEN_W       = 7;
    localparam int SH_W        = 6;
    localparam int TT_W        = 2 * MANT_BITS;
    localparam int BIG_W       = 2 * TT_W;
    localparam int SUM_W       = 45;
    localparam int C_W         = 29;
    localparam int W1_W        = WEIGHT_BITS + 1;
    localparam int PROD_W      = W1_W + 1 + C_W;
    localparam int N_W         = PROD_W + 2;
    localparam int Z_W         = 32;
    localparam int QP_W        = 2 * Z_W;
    localparam int DIV_STAGES  = WEIGHT_BITS;
    localparam int NSTAGE      = 13 + DIV_STAGES;
    localparam int DATA_IN_W   = 5 * SAMPLE_BITS;
    localparam int DATA_IN_PAD = ((DATA_IN_W + 7) / 8) * 8;
    localparam int DATA_OUT_PAD = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam logic [EPS_W-1:0] EPS_RESET = 32'd4295;
    localparam logic [Z_W-1:0]   RECIP3    = 32'hAAAA_AAAB;

    typedef struct packed {
        logic [SUM_W-1:0]        rem0;
        logic [SUM_W-1:0]        rem2;
        logic [SUM_W-1:0]        sum;
        logic [WEIGHT_BITS-1:0]  q0;
        logic [WEIGHT_BITS-1:0]  q2;
        logic signed [C_W-1:0]   c0;
        logic signed [C_W-1:0]   c1;
        logic signed [C_W-1:0]   c2;
    } div_t;

    typedef struct packed {
        logic signed [C_W-1:0] c0;
        logic signed [C_W-1:0] c1;
        logic signed [C_W-1:0] c2;
    } cand_t;

    // Bit length of an 8-bit chunk (0 when zero).
    function automatic logic [3:0] len8(input logic [7:0] x);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (x[i]) begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ----- src/w5r_div_step.sv -----
// One restoring-division step for both weight quotients, registered.
module w5r_div_step (
    input  logic          clk,
    input  logic          en,
    input  w5r_pkg::div_t din,
    output w5r_pkg::div_t dout
);

    logic [w5r_pkg::SUM_W:0] sh0;
    logic [w5r_pkg::SUM_W:0] sh2;
    logic                    ge0;
    logic                    ge2;
    w5r_pkg::div_t           dout_next;
    w5r_pkg::div_t           dout_reg;

    always_comb
    begin
        sh0 = {din.rem0, 1'b0};
        sh2 = {din.rem2, 1'b0};
        ge0 = sh0 >= {1'b0, din.sum};
        ge2 = sh2 >= {1'b0, din.sum};
        dout_next      = din;
        dout_next.rem0 = ge0 ? w5r_pkg::SUM_W'(sh0 - {1'b0, din.sum})
                             : w5r_pkg::SUM_W'(sh0);
        dout_next.rem2 = ge2 ? w5r_pkg::SUM_W'(sh2 - {1'b0, din.sum})
                             : w5r_pkg::SUM_W'(sh2);
        dout_next.q0   = {din.q0[w5r_pkg::WEIGHT_BITS-2:0], ge0};
        dout_next.q2   = {din.q2[w5r_pkg::WEIGHT_BITS-2:0], ge2};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ----- src/weno5_reconstruct_core.sv -----
// Top level: fully pipelined fifth-order WENO (Jiang-Shu) interface reconstruction.
//
// Takes a five-cell stencil (i-2 .. i+2, signed Q8.16) per item and returns the
// WENO5 value at i+1/2, saturated to Q8.16. One item per cycle is sustained while
// m_tready is high; most stages are the 16-step restoring divider that forms the
// nonlinear weights (one quotient bit per stage, both weights in parallel). Every
// stage has its own valid bit and loads when empty or when the next stage moves,
// so bubbles collapse and input flows while a result waits at the output register
// until the pipe fills. smoothness_epsilon (units of 2^-32, reset 4295) is written
// via cfg_valid/cfg_data, by the user only while the pipe is empty (not enforced).
`include "weno5_reconstruct_core_macros.svh"

module weno5_reconstruct_core (
    input  logic        clk,
    input  logic        rst_n,
    // stencil in
    input  logic        s_tvalid,
    output logic        s_tready,
    // sample_m2, sample_m1, sample_c, sample_p1, sample_p2 (24 bits each)
    input  logic [w5r_pkg::DATA_IN_PAD-1:0] s_tdata,
    // result out
    output logic        m_tvalid,
    input  logic        m_tready,
    // interface_value (24 bits)
    output logic [w5r_pkg::DATA_OUT_PAD-1:0] m_tdata,
    // epsilon register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [w5r_pkg::EPS_W-1:0] cfg_data
);

    localparam int NS = w5r_pkg::NSTAGE;
    localparam int SB = w5r_pkg::SAMPLE_BITS;
    localparam int CW = w5r_pkg::C_W;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] en;

    logic [w5r_pkg::EPS_W-1:0] eps_reg;

    // ---------------- handshake ----------------
    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = s_tvalid;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            eps_reg <= w5r_pkg::EPS_RESET;
        end
        else
        begin
            vld_reg <= vld_next;
            if (cfg_valid)
            begin
                eps_reg <= cfg_data;
            end
        end
    end

    assign s_tready  = en[0];
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[NS-1];

    // ---------------- stage 0: differences and candidates ----------------
    logic signed [SB-1:0] v0, v1, v2, v3, v4;
    logic signed [CW-1:0] x0, x1, x2, x3, x4;
    logic signed [CW-1:0] a_d [3];
    logic signed [CW-1:0] b_d [3];
    w5r_pkg::cand_t       cand_next;
    logic [w5r_pkg::MAG_W-1:0] ma_reg [3];
    logic [w5r_pkg::MAG_W-1:0] mb_reg [3];
    w5r_pkg::cand_t       cp_reg [8];

    always_comb
    begin
        v0 = s_tdata[0*SB +: SB];
        v1 = s_tdata[1*SB +: SB];
        v2 = s_tdata[2*SB +: SB];
        v3 = s_tdata[3*SB +: SB];
        v4 = s_tdata[4*SB +: SB];
        x0 = CW'(v0);
        x1 = CW'(v1);
        x2 = CW'(v2);
        x3 = CW'(v3);
        x4 = CW'(v4);
        a_d[0] = x0 - (x1 <<< 1) + x2;
        b_d[0] = x0 - (x1 <<< 2) + (x2 <<< 1) + x2;
        a_d[1] = x1 - (x2 <<< 1) + x3;
        b_d[1] = x1 - x3;
        a_d[2] = x2 - (x3 <<< 1) + x4;
        b_d[2] = (x2 <<< 1) + x2 - (x3 <<< 2) + x4;
        cand_next.c0 = (x0 <<< 1) - ((x1 <<< 3) - x1) + (x2 <<< 3) + (x2 <<< 1) + x2;
        cand_next.c1 = (x2 <<< 2) + x2 + (x3 <<< 1) - x1;
        cand_next.c2 = (x2 <<< 1) + (x3 <<< 2) + x3 - x4;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < 3; k++) begin
                ma_reg[k] <= w5r_pkg::MAG_W'(a_d[k] < 0 ? -a_d[k] : a_d[k]);
                mb_reg[k] <= w5r_pkg::MAG_W'(b_d[k] < 0 ? -b_d[k] : b_d[k]);
            end
            cp_reg[0] <= cand_next;
        end
        for (int k = 1; k < 8; k++) begin
            if (en[k])
            begin
                cp_reg[k] <= cp_reg[k-1];
            end
        end
    end

    // ---------------- stage 1: squares ----------------
    logic [w5r_pkg::SQ_W-1:0] sa_reg [3];
    logic [w5r_pkg::SQ_W-1:0] sb_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int k = 0; k < 3; k++) begin
                sa_reg[k] <= ma_reg[k] * ma_reg[k];
                sb_reg[k] <= mb_reg[k] * mb_reg[k];
            end
        end
    end

    // ---------------- stage 2: 12*(beta+eps) ----------------
    logic [w5r_pkg::S_W-1:0] e12;
    logic [w5r_pkg::S_W-1:0] sa_x [3];
    logic [w5r_pkg::S_W-1:0] sb_x [3];
    logic [w5r_pkg::S_W-1:0] sm2_reg [3];

    always_comb
    begin
        e12 = (w5r_pkg::S_W'(eps_reg) << 3) + (w5r_pkg::S_W'(eps_reg) << 2);
        for (int k = 0; k < 3; k++) begin
            sa_x[k] = w5r_pkg::S_W'(sa_reg[k]);
            sb_x[k] = w5r_pkg::S_W'(sb_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int k = 0; k < 3; k++) begin
                sm2_reg[k] <= (sa_x[k] << 3) + (sa_x[k] << 2) + sa_x[k]
                            + (sb_x[k] << 1) + sb_x[k] + e12;
            end
        end
    end

    // ---------------- stage 3: max ----------------
    logic [w5r_pkg::S_W-1:0] sm3_reg [3];
    logic [w5r_pkg::S_W-1:0] mx_reg;
    logic [w5r_pkg::S_W-1:0] mx01;

    assign mx01 = (sm2_reg[1] > sm2_reg[0]) ? sm2_reg[1] : sm2_reg[0];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            sm3_reg <= sm2_reg;
            mx_reg  <= (sm2_reg[2] > mx01) ? sm2_reg[2] : mx01;
        end
    end

    // ---------------- stage 4: per-chunk bit lengths ----------------
    logic [w5r_pkg::S_W-1:0] sm4_reg [3];
    logic [3:0]              clen_reg [w5r_pkg::CHUNKS];
    logic [8*w5r_pkg::CHUNKS-1:0] mx_pad;

    assign mx_pad = (8*w5r_pkg::CHUNKS)'(mx_reg);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            sm4_reg <= sm3_reg;
            for (int j = 0; j < w5r_pkg::CHUNKS; j++) begin
                clen_reg[j] <= w5r_pkg::len8(mx_pad[8*j +: 8]);
            end
        end
    end

    // ---------------- stage 5: normalizing shift ----------------
    logic [w5r_pkg::S_W-1:0]  sm5_reg [3];
    logic [w5r_pkg::SH_W-1:0] sh_reg;
    logic [w5r_pkg::LEN_W-1:0] blen;

    always_comb
    begin
        blen = '0;
        for (int j = 0; j < w5r_pkg::CHUNKS; j++) begin
            if (clen_reg[j] != 4'd0)
            begin
                blen = w5r_pkg::LEN_W'(8 * j) + w5r_pkg::LEN_W'(clen_reg[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            sm5_reg <= sm4_reg;
            sh_reg  <= (blen > w5r_pkg::LEN_W'(w5r_pkg::MANT_BITS))
                     ? w5r_pkg::SH_W'(blen - w5r_pkg::LEN_W'(w5r_pkg::MANT_BITS))
                     : '0;
        end
    end

    // ---------------- stage 6: mantissas squared ----------------
    logic [w5r_pkg::MANT_BITS-1:0] tm [3];
    logic [w5r_pkg::TT_W-1:0]      tt_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++) begin
            tm[k] = w5r_pkg::MANT_BITS'(sm5_reg[k] >> sh_reg);
            if (tm[k] == '0)
            begin
                tm[k] = w5r_pkg::MANT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            for (int k = 0; k < 3; k++) begin
                tt_reg[k] <= tm[k] * tm[k];
            end
        end
    end

    // ---------------- stage 7: cross products ----------------
    logic [w5r_pkg::BIG_W-1:0] big0_reg, p02_reg, p01_reg;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            big0_reg <= tt_reg[1] * tt_reg[2];
            p02_reg  <= tt_reg[0] * tt_reg[2];
            p01_reg  <= tt_reg[0] * tt_reg[1];
        end
    end

    // ---------------- stage 8: terms and sum, divider setup ----------------
    w5r_pkg::div_t d8_reg;
    w5r_pkg::div_t d8_next;
    logic [w5r_pkg::SUM_W-1:0] b0x, b1x, b2x;

    always_comb
    begin
        b0x = w5r_pkg::SUM_W'(big0_reg);
        b1x = (w5r_pkg::SUM_W'(p02_reg) << 2) + (w5r_pkg::SUM_W'(p02_reg) << 1);
        b2x = (w5r_pkg::SUM_W'(p01_reg) << 1) + w5r_pkg::SUM_W'(p01_reg);
        d8_next.rem0 = b0x;
        d8_next.rem2 = b2x;
        d8_next.sum  = b0x + b1x + b2x;
        d8_next.q0   = '0;
        d8_next.q2   = '0;
        d8_next.c0   = cp_reg[7].c0;
        d8_next.c1   = cp_reg[7].c1;
        d8_next.c2   = cp_reg[7].c2;
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            d8_reg <= d8_next;
        end
    end

    // ---------------- stages 9..24: weight division ----------------
    w5r_pkg::div_t divq [w5r_pkg::DIV_STAGES+1];

    assign divq[0] = d8_reg;

    for (genvar i = 0; i < w5r_pkg::DIV_STAGES; i++) begin : g_div
        w5r_div_step u_step (
            .clk  (clk),
            .en   (en[9+i]),
            .din  (divq[i]),
            .dout (divq[i+1])
        );
    end

    localparam int DL = 8 + w5r_pkg::DIV_STAGES;

    // ---------------- stage 25: weighted candidates ----------------
    w5r_pkg::div_t dq;
    logic [w5r_pkg::W1_W-1:0] w1;
    logic signed [w5r_pkg::PROD_W-1:0] pr_reg [3];

    assign dq = divq[w5r_pkg::DIV_STAGES];
    assign w1 = (w5r_pkg::W1_W'(1) << w5r_pkg::WEIGHT_BITS)
              - w5r_pkg::W1_W'(dq.q0) - w5r_pkg::W1_W'(dq.q2);

    always_ff @(posedge clk)
    begin
        if (en[DL+1])
        begin
            pr_reg[0] <= $signed({2'b0, dq.q0}) * dq.c0;
            pr_reg[1] <= $signed({1'b0, w1}) * dq.c1;
            pr_reg[2] <= $signed({2'b0, dq.q2}) * dq.c2;
        end
    end

    // ---------------- stage 26: blend, magnitude, round ----------------
    logic signed [w5r_pkg::N_W-1:0] nsum;
    logic [w5r_pkg::N_W-1:0]        nmag;
    logic [w5r_pkg::N_W-1:0]        nrnd;
    logic [w5r_pkg::Z_W-1:0]        z_reg;
    logic                           neg1_reg;

    always_comb
    begin
        nsum = w5r_pkg::N_W'(pr_reg[0]) + w5r_pkg::N_W'(pr_reg[1])
             + w5r_pkg::N_W'(pr_reg[2]);
        nmag = nsum[w5r_pkg::N_W-1] ? w5r_pkg::N_W'(-nsum) : w5r_pkg::N_W'(nsum);
        // + 3*2^16 is half of 6*W; dividing by 2^17 first leaves a divide by 3
        nrnd = nmag + (w5r_pkg::N_W'(3) << w5r_pkg::WEIGHT_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en[DL+2])
        begin
            z_reg    <= w5r_pkg::Z_W'(nrnd >> (w5r_pkg::WEIGHT_BITS + 1));
            neg1_reg <= nsum[w5r_pkg::N_W-1];
        end
    end

    // ---------------- stage 27: divide by 3 via reciprocal ----------------
    logic [w5r_pkg::QP_W-1:0] qp_reg;
    logic                     neg2_reg;

    always_ff @(posedge clk)
    begin
        if (en[DL+3])
        begin
            qp_reg   <= z_reg * w5r_pkg::RECIP3;
            neg2_reg <= neg1_reg;
        end
    end

    // ---------------- stage 28: sign and saturation ----------------
    logic [w5r_pkg::Z_W-2:0]   qv;
    logic signed [w5r_pkg::Z_W:0] rv;
    logic signed [w5r_pkg::Z_W:0] hi_lim;
    logic signed [w5r_pkg::Z_W:0] lo_lim;
    logic [SB-1:0]             res_next;
    logic [SB-1:0]             res_reg;

    always_comb
    begin
        qv     = qp_reg[w5r_pkg::QP_W-1 -: (w5r_pkg::Z_W-1)];
        rv     = neg2_reg ? -$signed({2'b0, qv}) : $signed({2'b0, qv});
        hi_lim = (w5r_pkg::Z_W+1)'((1 << (SB - 1)) - 1);
        lo_lim = -hi_lim - (w5r_pkg::Z_W+1)'(1);
        if (rv > hi_lim)
        begin
            res_next = SB'(hi_lim);
        end
        else if (rv < lo_lim)
        begin
            res_next = SB'(lo_lim);
        end
        else
        begin
            res_next = SB'(rv);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            res_reg <= res_next;
        end
    end

    assign m_tdata = w5r_pkg::DATA_OUT_PAD'(res_reg);

    // ---------------- checks ----------------
    `W5R_ASSERT_IMP(a_stall_full, !s_tready, &vld_reg, "input stalled with a bubble in the pipe")
    `W5R_ASSERT_NXT(a_accept_enters, s_tvalid && s_tready, vld_reg[0], "accepted item lost at entry")
    `W5R_ASSERT_IMP(a_weight_sum, vld_reg[DL],
        ({1'b0, dq.q0} + {1'b0, dq.q2}) <= (w5r_pkg::W1_W'(1) << w5r_pkg::WEIGHT_BITS),
        "outer weights exceed unity")

endmodule

// ----- tb/sv/weno5_reconstruct_checker.sv -----
`timescale 1ns / 100ps
// Checker: watches the stencil and result channels, predicts WENO5 values and compares.
module weno5_reconstruct_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [w5r_pkg::DATA_IN_PAD-1:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [w5r_pkg::DATA_OUT_PAD-1:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [w5r_pkg::EPS_W-1:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    logic [w5r_pkg::EPS_W-1:0]        eps_q;
    logic [w5r_pkg::SAMPLE_BITS-1:0]  value_queue[$];

    assign pending = value_queue.size();

    function automatic longint unsigned mag64(input longint x);
        return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    function automatic longint unsigned indicator(input longint a, input longint b,
                                                  input logic [w5r_pkg::EPS_W-1:0] eps);
        longint unsigned ua, ub, e;
        ua = mag64(a);
        ub = mag64(b);
        e  = longint'(eps) * 12;
        return 13 * ua * ua + 3 * ub * ub + e;
    endfunction

    function automatic logic [w5r_pkg::SAMPLE_BITS-1:0] weno_value(
        input logic [w5r_pkg::DATA_IN_PAD-1:0] d, input logic [w5r_pkg::EPS_W-1:0] eps);
        longint v[5];
        longint unsigned s[3], t[3], m, tt0, tt1, tt2, b0, b1, b2, sum, w0, w1, w2, den, q;
        longint c0, c1, c2, n, r, hi, lo;
        int sh, len;
        for (int k = 0; k < 5; k++)
            v[k] = longint'($signed(d[k*w5r_pkg::SAMPLE_BITS +: w5r_pkg::SAMPLE_BITS]));
        s[0] = indicator(v[0] - 2*v[1] + v[2], v[0] - 4*v[1] + 3*v[2], eps);
        s[1] = indicator(v[1] - 2*v[2] + v[3], v[1] - v[3], eps);
        s[2] = indicator(v[2] - 2*v[3] + v[4], 3*v[2] - 4*v[3] + v[4], eps);
        m = s[0];
        if (s[1] > m) m = s[1];
        if (s[2] > m) m = s[2];
        len = 0;
        for (int i = 0; i < 64; i++)
            if (m[i]) len = i + 1;
        sh = (len > w5r_pkg::MANT_BITS) ? len - w5r_pkg::MANT_BITS : 0;
        for (int k = 0; k < 3; k++)
        begin
            t[k] = s[k] >> sh;
            if (t[k] == 0) t[k] = 1;
        end
        tt0 = t[0]*t[0];
        tt1 = t[1]*t[1];
        tt2 = t[2]*t[2];
        b0  = tt1*tt2;
        b1  = 6*tt0*tt2;
        b2  = 3*tt0*tt1;
        sum = b0 + b1 + b2;
        w0 = (b0 << w5r_pkg::WEIGHT_BITS) / sum;
        w2 = (b2 << w5r_pkg::WEIGHT_BITS) / sum;
        w1 = (64'd1 << w5r_pkg::WEIGHT_BITS) - w0 - w2;
        c0 = 2*v[0] - 7*v[1] + 11*v[2];
        c1 = -v[1] + 5*v[2] + 2*v[3];
        c2 = 2*v[2] + 5*v[3] - v[4];
        n = longint'(w0)*c0 + longint'(w1)*c1 + longint'(w2)*c2;
        den = 6 * (64'd1 << w5r_pkg::WEIGHT_BITS);
        q = (mag64(n) + den/2) / den;
        r = (n < 0) ? -longint'(q) : longint'(q);
        hi = (64'sd1 <<< (w5r_pkg::SAMPLE_BITS-1)) - 1;
        lo = -hi - 1;
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return r[w5r_pkg::SAMPLE_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_q      <= w5r_pkg::EPS_RESET;
            fail_count <= 0;
            value_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                eps_q <= cfg_data;
            if (s_tvalid && s_tready)
                value_queue.push_back(weno_value(s_tdata, eps_q));
            if (m_tvalid && m_tready)
            begin
                if (value_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             m_tdata[w5r_pkg::SAMPLE_BITS-1:0]);
                    fail_count <= fail_count + 1;
                end
                else if (value_queue[0] !== m_tdata[w5r_pkg::SAMPLE_BITS-1:0])
                begin
                    $display("%0t: interface_value mismatch, expected %h, actual %h", $time,
                             value_queue[0], m_tdata[w5r_pkg::SAMPLE_BITS-1:0]);
                    fail_count <= fail_count + 1;
                    void'(value_queue.pop_front());
                end
                else
                    void'(value_queue.pop_front());
            end
        end
    end
endmodule

// ----- tb/sv/tb_weno5_reconstruct_core.sv -----
`timescale 1ns / 100ps
// Testbench top: stimulus, epsilon phases and verdict for the WENO5 reconstruction core.
module tb_weno5_reconstruct_core;

    localparam int LATENCY   = 29;
    localparam int LIMIT     = 400000;
    localparam int RAND_ITEMS = 650;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [w5r_pkg::DATA_IN_PAD-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [w5r_pkg::DATA_OUT_PAD-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [w5r_pkg::EPS_W-1:0] cfg_data = '0;
    int fail_count, pending, cycles = 0, burst_left = 0;
    logic [w5r_pkg::SAMPLE_BITS-1:0] stencil[5];

    always #5 clk = ~clk;

    weno5_reconstruct_core dut (.*);

    weno5_reconstruct_checker checker_i (.*);

    // receiver stall pattern: long free-running stretches mixed with random stalls
    always @(negedge clk)
    begin
        cycles <= cycles + 1;
        if ((cycles / 512) % 3 == 0)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
        if (cycles > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end

    function automatic logic [w5r_pkg::SAMPLE_BITS-1:0] rand_sample(input int mode);
        case (mode)
            0: return w5r_pkg::SAMPLE_BITS'($urandom());
            1: return w5r_pkg::SAMPLE_BITS'($signed($urandom_range(0, 2000)) - 1000);
            2: return {1'b0, {(w5r_pkg::SAMPLE_BITS-1){1'b1}}};
            default: return {1'b1, {(w5r_pkg::SAMPLE_BITS-1){1'b0}}};
        endcase
    endfunction

    // one item; bursts with random gaps, valid kept high across a burst
    task automatic send_stencil(input bit gaps);
        int gap;
        if (gaps && burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tdata  <= {stencil[4], stencil[3], stencil[2], stencil[1], stencil[0]};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        if (burst_left > 0) burst_left--;
    endtask

    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_epsilon(input logic [w5r_pkg::EPS_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        int mode;
        for (int i = 0; i < count; i++)
        begin
            mode = $urandom_range(0, 9);
            for (int k = 0; k < 5; k++)
                stencil[k] = rand_sample(mode < 4 ? 0 : (mode < 8 ? 1 :
                                         $urandom_range(0, 3)));
            // smooth ramps exercise the near-linear weight path
            if (mode == 9)
                for (int k = 0; k < 5; k++)
                    stencil[k] = w5r_pkg::SAMPLE_BITS'(k * 300);
            send_stencil(1'b1);
            if (i == count / 2) drain_pipe();
        end
    endtask

    initial
    begin
        logic [w5r_pkg::EPS_W-1:0] eps_set[4];
        eps_set = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd4295};
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // directed: flat, extremes, discontinuities, extrapolating shock
        for (int d = 0; d < 20; d++)
        begin
            for (int k = 0; k < 5; k++)
                stencil[k] = '0;
            case (d % 5)
                0: ;
                1: for (int k = 0; k < 5; k++) stencil[k] = rand_sample(2);
                2: for (int k = 0; k < 5; k++) stencil[k] = rand_sample(3);
                3: for (int k = 0; k < 5; k++) stencil[k] = rand_sample(k % 2 ? 2 : 3);
                default: for (int k = 0; k < 5; k++) stencil[k] = rand_sample(k < 2 ? 3 : 2);
            endcase
            if (d >= 10) stencil[d % 5] = rand_sample(d % 2 ? 2 : 3);
            send_stencil(1'b0);
        end
        drain_pipe();
        // epsilon phases: zero, one, full scale, back to reset value
        for (int p = 0; p < 4; p++)
        begin
            write_epsilon(eps_set[p]);
            for (int k = 0; k < 5; k++) stencil[k] = '0;
            send_stencil(1'b0);
            random_phase(RAND_ITEMS / 5);
            drain_pipe();
        end
        write_epsilon($urandom());
        random_phase(RAND_ITEMS / 5);
        drain_pipe();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- weno5_reconstruct_core.f -----
+incdir+src
src/w5r_pkg.sv
src/w5r_div_step.sv
src/weno5_reconstruct_core.sv
tb/sv/weno5_reconstruct_checker.sv
tb/sv/tb_weno5_reconstruct_core.sv
